/* rtl/core/oaht_pkg.sv */
// ----------------------------------------------------------------------------
// Hash table shared definitions
// Table geometry, field widths, codes and the structs passed between the
// engine, the slot store and the register block.
// ----------------------------------------------------------------------------
package oaht_pkg;

   // Number of slots; must be a power of two (2 to 64) so that the slot
   // number wraps naturally in SLOT_W bits.
   localparam int TABLE_SIZE = 16;
   localparam int SLOT_W     = $clog2(TABLE_SIZE);
   localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

   localparam int KEY_W      = 32;
   localparam int IDX_W      = 6;
   localparam int CNT_OUT_W  = 7;
   localparam int COEF_W     = 6;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [COEF_W-1:0] LINEAR_RESET    = 6'd8;
   localparam logic [COEF_W-1:0] QUADRATIC_RESET = 6'd3;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_DUMP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_EMPTY    = 2'd0,
      ST_DELETED  = 2'd1,
      ST_OCCUPIED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OUT_INSERTED  = 3'd0,
      OUT_PRESENT   = 3'd1,
      OUT_FULL      = 3'd2,
      OUT_DELETED   = 3'd3,
      OUT_NOT_FOUND = 3'd4,
      OUT_FOUND     = 3'd5,
      OUT_DUMP      = 3'd6
   } outcome_type;

   // Register index, taken from the word address of the CSR port
   typedef enum logic [0:0] {
      REG_LINEAR    = 1'b0,
      REG_QUADRATIC = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] linear;
      logic [COEF_W-1:0] quadratic;
   } coef_type;

   typedef struct packed {
      logic       rd_en;
      slot_type   rd_addr;
      logic       wr_en;
      logic       wr_key_en;
      slot_type   wr_addr;
      status_type wr_status;
      logic [KEY_W-1:0] wr_key;
   } store_req_type;

   typedef struct packed {
      status_type status;
      logic [KEY_W-1:0] key;
   } store_rsp_type;

endpackage

/* rtl/core/oaht_req_if.sv */
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one table command and its key.
// ----------------------------------------------------------------------------
interface oaht_req_if import oaht_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       cmd;
   logic [KEY_W-1:0] key;

   modport source (output valid, cmd, key, input ready);
   modport sink   (input valid, cmd, key, output ready);
endinterface

/* rtl/core/oaht_rsp_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result of a table command.
// ----------------------------------------------------------------------------
interface oaht_rsp_if import oaht_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [2:0]           outcome;
   logic [IDX_W-1:0]     slot_index;
   logic [1:0]           slot_status;
   logic [KEY_W-1:0]     slot_key;
   logic [CNT_OUT_W-1:0] probe_count;
   logic                 last;

   modport source (output valid, outcome, slot_index, slot_status, slot_key,
                   probe_count, last, input ready);
   modport sink   (input valid, outcome, slot_index, slot_status, slot_key,
                   probe_count, last, output ready);
endinterface

/* rtl/core/oaht_csr.sv */
// ----------------------------------------------------------------------------
// Hash table register block
// APB-style access to the linear and quadratic probe coefficients.
// ----------------------------------------------------------------------------
module oaht_csr import oaht_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output coef_type          coef
);

   logic [COEF_W-1:0] linear_ff, linear_in;
   logic [COEF_W-1:0] quadratic_ff, quadratic_in;
   logic              wr_fire;
   reg_index_type     reg_sel;

   assign csr_pready = 1'b1;
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = reg_index_type'(csr_paddr[2]);

   always_comb begin
      linear_in    = linear_ff;
      quadratic_in = quadratic_ff;
      if (wr_fire) begin
         case (reg_sel)
            REG_LINEAR:    linear_in    = csr_pwdata[COEF_W-1:0];
            REG_QUADRATIC: quadratic_in = csr_pwdata[COEF_W-1:0];
            default:       linear_in    = linear_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         linear_ff    <= LINEAR_RESET;
         quadratic_ff <= QUADRATIC_RESET;
      end else begin
         linear_ff    <= linear_in;
         quadratic_ff <= quadratic_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_LINEAR:    csr_prdata = CSR_DW'(linear_ff);
         REG_QUADRATIC: csr_prdata = CSR_DW'(quadratic_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign coef.linear    = linear_ff;
   assign coef.quadratic = quadratic_ff;

endmodule

/* rtl/core/oaht_store.sv */
// ----------------------------------------------------------------------------
// Hash table slot store
// Status and key memories with one registered read port and one write port.
// Per-slot valid flops make unwritten slots read as empty after reset.
// ----------------------------------------------------------------------------
module oaht_store import oaht_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  store_req_type store_req,
   output store_rsp_type store_rsp
);

   status_type       status_mem [TABLE_SIZE];
   logic [KEY_W-1:0] key_mem    [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] slot_vld_ff;

   status_type       rd_status_ff;
   logic             rd_vld_ff;
   logic [KEY_W-1:0] rd_key_ff;

   // Valid bits: cleared at once by reset, set by the first write
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
      end else if (store_req.wr_en) begin
         slot_vld_ff[store_req.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         status_mem[store_req.wr_addr] <= store_req.wr_status;
      end
      if (store_req.rd_en) begin
         rd_status_ff <= status_mem[store_req.rd_addr];
         rd_vld_ff    <= slot_vld_ff[store_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.wr_en && store_req.wr_key_en) begin
         key_mem[store_req.wr_addr] <= store_req.wr_key;
      end
      if (store_req.rd_en) begin
         rd_key_ff <= key_mem[store_req.rd_addr];
      end
   end

   assign store_rsp.status = rd_vld_ff ? rd_status_ff : ST_EMPTY;
   assign store_rsp.key    = rd_key_ff;

endmodule

/* rtl/core/oaht_engine.sv */
// ----------------------------------------------------------------------------
// Hash table probe engine
// Sequencer that probes the slot store one slot per cycle, commits the
// write-back and holds the result register.
// ----------------------------------------------------------------------------
module oaht_engine import oaht_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  coef_type             coef,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic [KEY_W-1:0]     req_key,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_outcome,
   output logic [IDX_W-1:0]     rsp_slot_index,
   output logic [1:0]           rsp_slot_status,
   output logic [KEY_W-1:0]     rsp_slot_key,
   output logic [CNT_OUT_W-1:0] rsp_probe_count,
   output logic                 rsp_last,
   output store_req_type        store_req,
   input  store_rsp_type        store_rsp
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_FINISH,
      S_DUMP
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   slot_type         cur_ff, cur_in;
   slot_type         step_ff, step_in;
   logic [CNT_W-1:0] probes_ff, probes_in;
   slot_type         tomb_ff, tomb_in;
   logic             tomb_vld_ff, tomb_vld_in;
   logic             found_ff, found_in;
   logic             hit_vld_ff, hit_vld_in;

   logic                 out_vld_ff, out_vld_in;
   outcome_type          out_outcome_ff, out_outcome_in;
   logic [IDX_W-1:0]     out_index_ff, out_index_in;
   status_type           out_status_ff, out_status_in;
   logic [KEY_W-1:0]     out_key_ff, out_key_in;
   logic [CNT_OUT_W-1:0] out_probes_ff, out_probes_in;
   logic                 out_last_ff, out_last_in;

   logic             out_free;
   logic             key_match;
   logic             dump_last;
   slot_type         nxt_slot;
   slot_type         quad_step;
   logic [CNT_W-1:0] probes_inc;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      cur_in         = cur_ff;
      step_in        = step_ff;
      probes_in      = probes_ff;
      tomb_in        = tomb_ff;
      tomb_vld_in    = tomb_vld_ff;
      found_in       = found_ff;
      hit_vld_in     = hit_vld_ff;
      out_vld_in     = out_vld_ff && !rsp_ready;
      out_outcome_in = out_outcome_ff;
      out_index_in   = out_index_ff;
      out_status_in  = out_status_ff;
      out_key_in     = out_key_ff;
      out_probes_in  = out_probes_ff;
      out_last_in    = out_last_ff;
      store_req      = '0;

      out_free   = !out_vld_ff || rsp_ready;
      nxt_slot   = cur_ff + step_ff;
      quad_step  = SLOT_W'({coef.quadratic, 1'b0});
      probes_inc = probes_ff + 1'b1;
      key_match  = (store_rsp.status == ST_OCCUPIED) && (store_rsp.key == key_ff);
      dump_last  = (cur_ff == SLOT_W'(TABLE_SIZE - 1));

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in            = cmd_type'(req_cmd);
               key_in            = req_key;
               probes_in         = '0;
               tomb_vld_in       = 1'b0;
               found_in          = 1'b0;
               hit_vld_in        = 1'b0;
               store_req.rd_en   = 1'b1;
               if (cmd_type'(req_cmd) == CMD_DUMP) begin
                  cur_in            = '0;
                  store_req.rd_addr = '0;
                  state_in          = S_DUMP;
               end else begin
                  // Probe zero: key mod size; first step is c1 + c2
                  cur_in            = req_key[SLOT_W-1:0];
                  step_in           = SLOT_W'(coef.linear) + SLOT_W'(coef.quadratic);
                  store_req.rd_addr = req_key[SLOT_W-1:0];
                  state_in          = S_PROBE;
               end
            end
         end

         S_PROBE: begin
            probes_in = probes_inc;
            if (store_rsp.status == ST_EMPTY) begin
               hit_vld_in = 1'b1;
               state_in   = S_FINISH;
            end else if (key_match) begin
               found_in = 1'b1;
               state_in = S_FINISH;
            end else begin
               if (store_rsp.status == ST_DELETED && !tomb_vld_ff) begin
                  tomb_in     = cur_ff;
                  tomb_vld_in = 1'b1;
               end
               if (probes_inc == CNT_W'(TABLE_SIZE)) begin
                  state_in = S_FINISH;
               end else begin
                  // Offset differences grow by 2*c2 each probe
                  cur_in            = nxt_slot;
                  step_in           = step_ff + quad_step;
                  store_req.rd_en   = 1'b1;
                  store_req.rd_addr = nxt_slot;
               end
            end
         end

         S_FINISH: begin
            if (out_free) begin
               out_vld_in     = 1'b1;
               out_last_in    = 1'b1;
               out_probes_in  = CNT_OUT_W'(probes_ff);
               out_outcome_in = OUT_NOT_FOUND;
               out_index_in   = '0;
               out_status_in  = ST_EMPTY;
               out_key_in     = '0;
               state_in       = S_IDLE;
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (found_ff) begin
                        out_outcome_in = OUT_PRESENT;
                        out_index_in   = IDX_W'(cur_ff);
                        out_status_in  = ST_OCCUPIED;
                        out_key_in     = key_ff;
                     end else if (tomb_vld_ff || hit_vld_ff) begin
                        store_req.wr_en     = 1'b1;
                        store_req.wr_key_en = 1'b1;
                        store_req.wr_addr   = tomb_vld_ff ? tomb_ff : cur_ff;
                        store_req.wr_status = ST_OCCUPIED;
                        store_req.wr_key    = key_ff;
                        out_outcome_in      = OUT_INSERTED;
                        out_index_in        = IDX_W'(tomb_vld_ff ? tomb_ff : cur_ff);
                        out_status_in       = ST_OCCUPIED;
                        out_key_in          = key_ff;
                     end else begin
                        out_outcome_in = OUT_FULL;
                     end
                  end
                  CMD_DELETE: begin
                     if (found_ff) begin
                        store_req.wr_en     = 1'b1;
                        store_req.wr_addr   = cur_ff;
                        store_req.wr_status = ST_DELETED;
                        out_outcome_in      = OUT_DELETED;
                        out_index_in        = IDX_W'(cur_ff);
                        out_status_in       = ST_DELETED;
                     end
                  end
                  default: begin
                     if (found_ff) begin
                        out_outcome_in = OUT_FOUND;
                        out_index_in   = IDX_W'(cur_ff);
                        out_status_in  = ST_OCCUPIED;
                        out_key_in     = key_ff;
                     end
                  end
               endcase
            end
         end

         S_DUMP: begin
            if (out_free) begin
               out_vld_in     = 1'b1;
               out_outcome_in = OUT_DUMP;
               out_index_in   = IDX_W'(cur_ff);
               out_status_in  = store_rsp.status;
               out_key_in     = (store_rsp.status == ST_OCCUPIED) ? store_rsp.key : '0;
               out_probes_in  = '0;
               out_last_in    = dump_last;
               if (dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in            = cur_ff + 1'b1;
                  store_req.rd_en   = 1'b1;
                  store_req.rd_addr = cur_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         out_vld_ff  <= 1'b0;
         tomb_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         hit_vld_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cmd_ff         <= cmd_in;
         key_ff         <= key_in;
         cur_ff         <= cur_in;
         step_ff        <= step_in;
         probes_ff      <= probes_in;
         tomb_ff        <= tomb_in;
         tomb_vld_ff    <= tomb_vld_in;
         found_ff       <= found_in;
         hit_vld_ff     <= hit_vld_in;
         out_vld_ff     <= out_vld_in;
         out_outcome_ff <= out_outcome_in;
         out_index_ff   <= out_index_in;
         out_status_ff  <= out_status_in;
         out_key_ff     <= out_key_in;
         out_probes_ff  <= out_probes_in;
         out_last_ff    <= out_last_in;
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = out_vld_ff;
   assign rsp_outcome     = out_outcome_ff;
   assign rsp_slot_index  = out_index_ff;
   assign rsp_slot_status = out_status_ff;
   assign rsp_slot_key    = out_key_ff;
   assign rsp_probe_count = out_probes_ff;
   assign rsp_last        = out_last_ff;

endmodule

/* rtl/core/open_addressing_hash_table.sv */
// ----------------------------------------------------------------------------
// Open-addressing hash table with quadratic probing
// Commands arrive as req_ch transactions (insert, delete, search, dump) and
// each gives one rsp_ch transaction, or one per slot for dump with the last
// one flagged. Probe i visits slot (key + c1*i + c2*i*i) mod TABLE_SIZE,
// with c1 and c2 in registers 0 and 1 of the CSR port (reset 8 and 3).
// Insert, delete and search accept the command and issue the first read, then
// probe slot after slot through the single read port of the slot store, then
// write back and load the result register. A dump returns one slot per cycle
// while the result channel takes each result. The next command
// is accepted while the previous result still waits in the output register;
// a stalled result channel holds the engine at write-back or in the dump.
// All slots read as empty right after reset through per-slot valid bits;
// there is no clearing pass. Write the coefficients only while idle.
// ----------------------------------------------------------------------------
module open_addressing_hash_table import oaht_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   oaht_req_if.sink          req_ch,
   oaht_rsp_if.source        rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // Probe coefficients, live from the register block
   coef_type      coef;
   // Read/write traffic between engine and slot store
   store_req_type store_req;
   store_rsp_type store_rsp;

   oaht_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   // Slot memories: read data appears the cycle after the address
   oaht_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .store_rsp (store_rsp)
   );

   // Probe sequencer and result register
   oaht_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .coef            (coef),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_cmd         (req_ch.cmd),
      .req_key         (req_ch.key),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_outcome     (rsp_ch.outcome),
      .rsp_slot_index  (rsp_ch.slot_index),
      .rsp_slot_status (rsp_ch.slot_status),
      .rsp_slot_key    (rsp_ch.slot_key),
      .rsp_probe_count (rsp_ch.probe_count),
      .rsp_last        (rsp_ch.last),
      .store_req       (store_req),
      .store_rsp       (store_rsp)
   );

endmodule

/* rtl/core/oaht_checker.sv */
// ----------------------------------------------------------------------------
// Hash table port checker
// Concurrent checks on the command and result channels, bound to the top.
// ----------------------------------------------------------------------------
module oaht_checker import oaht_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [2:0]           rsp_outcome,
   input logic [IDX_W-1:0]     rsp_slot_index,
   input logic [1:0]           rsp_slot_status,
   input logic [KEY_W-1:0]     rsp_slot_key,
   input logic [CNT_OUT_W-1:0] rsp_probe_count,
   input logic                 rsp_last
);

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome)
         && $stable(rsp_slot_index) && $stable(rsp_slot_status)
         && $stable(rsp_slot_key) && $stable(rsp_probe_count) && $stable(rsp_last))
      else $error("result changed while stalled");

   // One command at a time: ready drops after each accepted transaction
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while busy");

   // Probe commands give a single result with a probe count in range
   a_probe_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != OUT_DUMP |-> rsp_last && rsp_probe_count != '0
         && rsp_probe_count <= CNT_OUT_W'(TABLE_SIZE))
      else $error("bad probe result framing");

   // Misses report an empty slot zero; table full means TABLE_SIZE probes made
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == OUT_FULL || rsp_outcome == OUT_NOT_FOUND)
         |-> rsp_slot_index == '0 && rsp_slot_status == ST_EMPTY && rsp_slot_key == '0
            && (rsp_outcome != OUT_FULL || rsp_probe_count == CNT_OUT_W'(TABLE_SIZE)))
      else $error("bad miss result fields");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_outcome     (rsp_ch.outcome),
   .rsp_slot_index  (rsp_ch.slot_index),
   .rsp_slot_status (rsp_ch.slot_status),
   .rsp_slot_key    (rsp_ch.slot_key),
   .rsp_probe_count (rsp_ch.probe_count),
   .rsp_last        (rsp_ch.last)
);
